// ----- hdl/lspg_pkg.sv -----
// lspg_pkg: shared constants, types and helpers of the led string pattern generator
// no dependencies; used by lspg_cell, lspg_divser and led_string_pattern_generator

package lspg_pkg;

	localparam int CNT_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int COLOR_W = 3 * BYTE_W;

	// leds in the string, a power of two so the led residues reduce to a mask
	localparam int LED_COUNT = 8;
	localparam int LED_W     = $clog2(LED_COUNT);

	// inverse of 5 modulo 2^32, exact division of multiples of 5
	localparam logic [CNT_W-1:0] INV_FIVE = 32'hCCCC_CCCD;

	// program codes
	localparam logic [BYTE_W-1:0] PROG_GRADIENT = 8'd1;
	localparam logic [BYTE_W-1:0] PROG_DOT      = 8'd2;

	// blink periods in ticks
	localparam int BLINK_FULL = 40;
	localparam int BLINK_HALF = 20;

	// full-white led after full-scale scaling: 255 * 255 >> 8
	localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFEFEFE;
	localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

	// flags from the tick analysis unit
	typedef struct packed {
		logic on_half;  // tick is a multiple of the half blink period
		logic on_full;  // tick is a multiple of the full blink period
	} lspg_phase_t;

	// bits 15:8 of c * 255
	function automatic logic [BYTE_W-1:0] scale_full(input logic [BYTE_W-1:0] c);
		scale_full = (c == '0) ? '0 : c - 8'd1;
	endfunction

	// startup colors, stored as {first, second, third}
	function automatic logic [COLOR_W-1:0] startup_color(input int idx);
		case (idx)
			0:       startup_color = 24'h00FF00;
			1:       startup_color = 24'hFF0000;
			2:       startup_color = 24'h0000FF;
			3:       startup_color = 24'hFFFFFF;
			5:       startup_color = 24'h808080;
			7:       startup_color = 24'h808080;
			default: startup_color = COLOR_BLACK;
		endcase
	endfunction

endpackage

// ----- hdl/lspg_cell.sv -----
// lspg_cell: one led slot of the frame chain, holds a 24-bit color
// depends on lspg_pkg

module lspg_cell #(
	parameter logic [23:0] RESET_COLOR = 24'h000000
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift_en,
	input  logic [lspg_pkg::COLOR_W-1:0] din,
	output logic [lspg_pkg::COLOR_W-1:0] dout
);

	logic [lspg_pkg::COLOR_W-1:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
		end else if (shift_en) begin
			color_q <= din;
		end
	end

	assign dout = color_q;

endmodule

// ----- hdl/lspg_divser.sv -----
// lspg_divser: analysis of a tick count by constant residues, no divider
// gives count mod LED_COUNT, (count / half period) mod LED_COUNT and the blink flags; depends on lspg_pkg

module lspg_divser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lspg_pkg::CNT_W-1:0]  cnt,
	output logic                        done,
	output logic [lspg_pkg::LED_W-1:0]  mod_n,
	output logic [lspg_pkg::LED_W-1:0]  quo_n,
	output lspg_pkg::lspg_phase_t       phase
);

	localparam int            IW      = lspg_pkg::LED_W;
	localparam logic [IW-1:0] INV_LOW = IW'(lspg_pkg::INV_FIVE);

	// half period is 4 * 5, full period 8 * 5: the low count bits give the
	// power-of-two part, the nibble sum gives the residue mod 5 (16 is 1 mod 5)
	logic [IW+1:0] low_q;
	logic [6:0]    nib_sum_q;
	logic          done_q;

	logic [4:0]    pair_sum [4];
	logic [5:0]    half_lo, half_hi;
	logic [6:0]    nib_sum;
	logic [4:0]    fold;
	logic          five_ok;

	// nibble sum as a shallow adder tree, loaded with the request
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pair_sum[k] = 5'(cnt[8*k+4 +: 4]) + 5'(cnt[8*k +: 4]);
		end
		half_lo = 6'(pair_sum[0]) + 6'(pair_sum[1]);
		half_hi = 6'(pair_sum[2]) + 6'(pair_sum[3]);
		nib_sum = 7'(half_lo) + 7'(half_hi);
	end

	// fold the stored sum once more, at most 22, then test for a multiple of 5
	always_comb begin
		fold    = 5'(nib_sum_q[6:4]) + 5'(nib_sum_q[3:0]);
		five_ok = (fold == 5'd0) || (fold == 5'd5) || (fold == 5'd10) ||
		          (fold == 5'd15) || (fold == 5'd20);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			low_q     <= '0;
			nib_sum_q <= '0;
		end else begin
			done_q <= start;
			if (start) begin
				low_q     <= cnt[IW+1:0];
				nib_sum_q <= nib_sum;
			end
		end
	end

	assign done          = done_q;
	// led count is a power of two
	assign mod_n         = low_q[IW-1:0];
	// exact quotient by 5 of count / 4, modulo LED_COUNT, valid on multiples of the half period only
	assign quo_n         = IW'(low_q[IW+1:2] * INV_LOW);
	assign phase.on_full = five_ok && (low_q[2:0] == 3'd0);
	assign phase.on_half = five_ok && (low_q[1:0] == 2'd0);

endmodule

// ----- hdl/led_string_pattern_generator.sv -----
// led_string_pattern_generator: top level, frame chain of led cells plus tick analysis
// depends on lspg_pkg, lspg_cell and lspg_divser
//
//  channel   direction  handshake              payload
//  in        to block   in_valid / in_stall     tick_count
//  out       from block out_valid / out_stall   led_index, slot_first, slot_second,
//                                               slot_third, last_led
//  cfg       to block   cfg_wr_en               cfg_wr_data (program select)
//
// a request with the last seen tick count is taken and gives nothing
// a new tick count holds in_stall high until its last led is in the output register:
//   the accept cycle loads the count analysis, ST_CALC waits for its residues,
//   then ST_EMIT moves one led per cycle out of the chain while the output is free
// out_stall holds the chain; an emitted led waits in the output register until taken
// reset loads the startup colors into the cells and clears the last count to zero

module led_string_pattern_generator (
	input  logic        clk,
	input  logic        arst_n,
	// tick request
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] tick_count,
	// led results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  led_index,
	output logic [7:0]  slot_first,
	output logic [7:0]  slot_second,
	output logic [7:0]  slot_third,
	output logic        last_led,
	// program select register
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int LED_COUNT = lspg_pkg::LED_COUNT;
	localparam int IW        = lspg_pkg::LED_W;
	localparam int CW        = lspg_pkg::COLOR_W;
	localparam int BW        = lspg_pkg::BYTE_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [lspg_pkg::CNT_W-1:0]   last_q;
	logic [BW-1:0]                prog_q;
	logic [IW-1:0]                led_q;   // led being emitted
	logic [IW-1:0]                pos_q;   // gradient position of that led
	logic                         out_valid_q;
	logic [2:0]                   led_index_q;
	logic [CW-1:0]                color_q;
	logic                         last_led_q;

	logic                         accept;
	logic                         start;
	logic                         calc_done;
	logic [IW-1:0]                mod_n, quo_n;
	lspg_pkg::lspg_phase_t        phase;
	logic                         out_free;
	logic                         shift_en;
	logic                         is_last;
	logic [CW-1:0]                head;
	logic [CW-1:0]                tail_in;
	logic [CW-1:0]                fresh;
	logic                         keep;
	logic [BW-1:0]                lvl;
	logic                         even_led;
	logic                         lit;

	// chain taps: tap[i] is the output of cell i
	logic [CW-1:0]                tap [LED_COUNT];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// a repeated count is taken and dropped
	assign start    = accept && (tick_count != last_q);
	assign out_free = !out_valid_q || !out_stall;
	assign shift_en = (state_q == ST_EMIT) && out_free;
	assign is_last  = (led_q == IW'(LED_COUNT - 1));
	assign head     = tap[0];

	// tick analysis runs while the frame waits in the chain
	lspg_divser u_divser (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cnt    (tick_count),
		.done   (calc_done),
		.mod_n  (mod_n),
		.quo_n  (quo_n),
		.phase  (phase)
	);

	// next color of the led now leaving the head of the chain
	always_comb begin
		lvl      = 8'(8'(pos_q) << 5);
		even_led = !led_q[0];
		fresh    = lspg_pkg::COLOR_BLACK;
		keep     = 1'b0;
		lit      = 1'b0;
		if (prog_q == lspg_pkg::PROG_GRADIENT) begin
			// red only, red sits in the second byte
			fresh = {8'h00, lspg_pkg::scale_full(lvl), 8'h00};
		end else if (prog_q == lspg_pkg::PROG_DOT) begin
			keep  = !phase.on_half;
			fresh = (led_q == quo_n) ? lspg_pkg::COLOR_WHITE : lspg_pkg::COLOR_BLACK;
		end else begin
			// blink: even leds lit on full period, odd leds on the half in between
			keep  = !phase.on_half && !phase.on_full;
			lit   = phase.on_full ? even_led : !even_led;
			fresh = lit ? lspg_pkg::COLOR_WHITE : lspg_pkg::COLOR_BLACK;
		end
		// a kept frame just rotates around the chain
		tail_in = keep ? head : fresh;
	end

	// frame chain: shifts toward cell 0, the new frame enters at the tail
	for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
		logic [CW-1:0] cell_din;
		if (i == LED_COUNT - 1) begin : g_tail
			assign cell_din = tail_in;
		end else begin : g_mid
			assign cell_din = tap[i+1];
		end
		lspg_cell #(
			.RESET_COLOR(lspg_pkg::startup_color(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.din      (cell_din),
			.dout     (tap[i])
		);
	end

	// program select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= '0;
		end else if (cfg_wr_en) begin
			prog_q <= cfg_wr_data;
		end
	end

	// sequencer with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			led_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			led_index_q <= '0;
			color_q     <= '0;
			last_led_q  <= 1'b0;
		end else begin
			// result taken and no new led loaded behind it
			if (out_valid_q && !out_stall && !shift_en) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						last_q  <= tick_count;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_done) begin
						led_q   <= '0;
						pos_q   <= mod_n;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						led_index_q <= 3'(led_q);
						color_q     <= head;
						last_led_q  <= is_last;
						led_q       <= led_q + IW'(1);
						pos_q       <= (pos_q == IW'(LED_COUNT - 1)) ? '0 : pos_q + IW'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign led_index   = led_index_q;
	assign slot_first  = color_q[CW-1 -: BW];
	assign slot_second = color_q[CW-BW-1 -: BW];
	assign slot_third  = color_q[BW-1:0];
	assign last_led    = last_led_q;

endmodule
